[design/spe_pkg.sv]
// Shared types and constants for the SPIR-V entry point scanner.
package spe_pkg;

  localparam logic [31:0] SPV_MAGIC = 32'h0723_0203;
  localparam int          POS_W     = 22;
  localparam logic [POS_W-1:0] HDR_WORDS = POS_W'(5);
  localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};
  localparam logic [15:0] OP_ENTRY  = 16'd15;
  localparam logic [15:0] NAME_WORD = 16'd3;
  localparam int          LEN_SHIFT = 16;
  localparam int          FIFO_DEPTH = 4;
  localparam int          FIFO_AW    = $clog2(FIFO_DEPTH);

  // Result kinds
  localparam logic KIND_CHUNK  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Scan status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_LEN   = 2'd1;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd2;
  localparam logic [1:0] ST_BAD_INSTR = 2'd3;

  // Register indexes
  localparam logic REG_MODULE_BYTES = 1'b0;
  localparam logic REG_WANTED_MODEL = 1'b1;

  typedef struct packed {
    logic [23:0] module_bytes;
    logic [31:0] wanted_model;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] chars;
    logic [2:0]  count;
    logic        name_end;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_out_t;

endpackage

[design/spe_cfg_regs.sv]
// APB-style register port holding module length and wanted execution model.
module spe_cfg_regs import spe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.module_bytes <= '0;
      cfg.wanted_model <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_MODULE_BYTES: cfg.module_bytes <= pwdata[23:0];
        REG_WANTED_MODEL: cfg.wanted_model <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODULE_BYTES: prdata = {8'd0, cfg.module_bytes};
      REG_WANTED_MODEL: prdata = cfg.wanted_model;
      default:          prdata = '0;
    endcase
  end

endmodule

[design/spe_scan_core.sv]
// Scan state and the per-word step: header checks, instruction walk, name chunks.
module spe_scan_core import spe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        step,
  input  logic [31:0] word,
  input  logic        fin,
  output step_out_t   res
);

  logic [POS_W-1:0] word_position, word_position_next;
  logic [POS_W-1:0] instr_start, instr_start_next;
  logic [15:0]      instr_length, instr_length_next;
  logic             is_match, is_match_next;
  logic             name_finished, name_finished_next;
  logic             stopped, stopped_next;
  logic [1:0]       status_code, status_code_next;
  logic [1:0]       status_upd;

  logic [POS_W-1:0] wc;
  logic             len_ok;
  logic [POS_W:0]   hdr_end;
  logic [15:0]      w_len;
  logic [15:0]      w_op;
  logic [POS_W:0]   p_end;
  logic [POS_W-1:0] rel;
  logic [POS_W:0]   rel_next;
  logic [2:0]       cnt;
  logic [31:0]      chars;
  logic             chunk_end;
  logic             chunk_valid;
  result_t          chunk;
  result_t          report;

  assign wc       = cfg.module_bytes[23:2];
  assign len_ok   = (wc > HDR_WORDS) && (cfg.module_bytes[1:0] == 2'b00);
  assign hdr_end  = {1'b0, instr_start} + {7'd0, instr_length};
  assign w_len    = word[31:LEN_SHIFT];
  assign w_op     = word[15:0];
  assign p_end    = {1'b0, word_position} + {7'd0, w_len};
  assign rel      = word_position - instr_start;
  assign rel_next = {1'b0, rel} + 1'b1;

  // Bytes up to the first NUL
  always_comb begin
    cnt = 3'd4;
    for (int i = 3; i >= 0; i--) begin
      if (word[8*i +: 8] == 8'd0) cnt = 3'(i);
    end
    for (int i = 0; i < 4; i++) begin
      chars[8*i +: 8] = (3'(i) < cnt) ? word[8*i +: 8] : 8'd0;
    end
  end

  assign chunk_end = (cnt != 3'd4) || (rel_next == {7'd0, instr_length});

  always_comb begin
    word_position_next = word_position;
    instr_start_next   = instr_start;
    instr_length_next  = instr_length;
    is_match_next      = is_match;
    name_finished_next = name_finished;
    stopped_next       = stopped;
    status_code_next   = status_code;
    chunk_valid        = 1'b0;

    if (len_ok && !stopped && word_position < wc) begin
      if (word_position == '0) begin
        if (word != SPV_MAGIC) begin
          stopped_next     = 1'b1;
          status_code_next = ST_BAD_MAGIC;
        end
      end else if (word_position >= HDR_WORDS) begin
        if ({1'b0, word_position} == hdr_end) begin
          if (w_len == 16'd0 || p_end > {1'b0, wc}) begin
            stopped_next     = 1'b1;
            status_code_next = ST_BAD_INSTR;
          end else begin
            instr_start_next   = word_position;
            instr_length_next  = w_len;
            is_match_next      = (w_op == OP_ENTRY) && (w_len > NAME_WORD);
            name_finished_next = 1'b0;
          end
        end else if (word_position > instr_start) begin
          if (rel == POS_W'(1)) begin
            if (word != cfg.wanted_model) is_match_next = 1'b0;
          end else if (rel >= POS_W'(NAME_WORD) && is_match && !name_finished) begin
            chunk_valid = 1'b1;
            if (chunk_end) name_finished_next = 1'b1;
          end
        end
      end
    end

    // the report carries the status including this word's checks
    status_upd = status_code_next;

    if (word_position < POS_MAX) word_position_next = word_position + 1'b1;

    if (fin) begin
      word_position_next = '0;
      instr_start_next   = HDR_WORDS;
      instr_length_next  = '0;
      is_match_next      = 1'b0;
      name_finished_next = 1'b0;
      stopped_next       = 1'b0;
      status_code_next   = ST_OK;
    end
  end

  always_comb begin
    chunk.kind      = KIND_CHUNK;
    chunk.chars     = chars;
    chunk.count     = cnt;
    chunk.name_end  = chunk_end;
    chunk.status    = ST_OK;
    report.kind     = KIND_REPORT;
    report.chars    = '0;
    report.count    = '0;
    report.name_end = 1'b0;
    report.status   = len_ok ? status_upd : ST_BAD_LEN;

    res.count  = {1'b0, chunk_valid} + {1'b0, fin};
    res.first  = chunk_valid ? chunk : report;
    res.second = report;
    if (!step) res.count = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_position <= '0;
      instr_start   <= HDR_WORDS;
      instr_length  <= '0;
      is_match      <= 1'b0;
      name_finished <= 1'b0;
      stopped       <= 1'b0;
      status_code   <= ST_OK;
    end else if (step) begin
      word_position <= word_position_next;
      instr_start   <= instr_start_next;
      instr_length  <= instr_length_next;
      is_match      <= is_match_next;
      name_finished <= name_finished_next;
      stopped       <= stopped_next;
      status_code   <= status_code_next;
    end
  end

endmodule

[design/spe_result_fifo.sv]
// Result queue: takes up to two results per cycle, hands out one.
module spe_result_fifo import spe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  step_out_t push,
  input  logic      pop,
  output logic      not_empty,
  output logic      has_room,
  output result_t   head
);

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   fill;
  logic [FIFO_AW-1:0] wr_ptr_plus;

  assign not_empty   = (fill != '0);
  // room for two words without looking at this cycle's pop
  assign has_room    = (fill <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign head        = mem[rd_ptr];
  assign wr_ptr_plus = wr_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.first;
    if (push.count == 2'd2) mem[wr_ptr_plus] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push.count);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(pop);
    end
  end

endmodule

[design/spirv_entry_point_scanner.sv]
// Top level of the SPIR-V entry point scanner: input register, scan step, result queue.
//
//  channel | handshake                    | payload
//  input   | in_valid / in_stall          | module_word, final_word
//  output  | out_valid / out_stall        | result_kind, name_chars, char_count,
//          |                              | name_end, scan_status
//  config  | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// One word per cycle while in_stall is low; a taken word waits in the input register until the queue has room.
// A word may give two results (a name chunk and the report); the four-entry queue
// accepts a step only while it has room for two, so in_stall rises when it fills.
// Synchronous reset clears the scan state, the registers and the queue.
// The queue decouples out_stall from the input side.
module spirv_entry_point_scanner import spe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] module_word,
  input  logic        final_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [31:0] name_chars,
  output logic [2:0]  char_count,
  output logic        name_end,
  output logic [1:0]  scan_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t        cfg;
  logic        word_valid;
  logic [31:0] word_q;
  logic        fin_q;
  logic        advance;
  logic        has_room;
  logic        pop;
  step_out_t   step_res;
  result_t     head;

  spe_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance  = word_valid && has_room;
  assign in_stall = word_valid && !has_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      word_valid <= 1'b1;
    end else if (advance) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      word_q <= module_word;
      fin_q  <= final_word;
    end
  end

  spe_scan_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (advance),
    .word (word_q),
    .fin  (fin_q),
    .res  (step_res)
  );

  assign pop = out_valid && !out_stall;

  spe_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (step_res),
    .pop       (pop),
    .not_empty (out_valid),
    .has_room  (has_room),
    .head      (head)
  );

  assign result_kind = head.kind;
  assign name_chars  = head.chars;
  assign char_count  = head.count;
  assign name_end    = head.name_end;
  assign scan_status = head.status;

endmodule

[sim/spe_scan_checker.sv]
// Scoreboard for the entry point scanner: mirrors registers, predicts results, compares.
module spe_scan_checker import spe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] module_word,
  input  logic        final_word,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        result_kind,
  input  logic [31:0] name_chars,
  input  logic [2:0]  char_count,
  input  logic        name_end,
  input  logic [1:0]  scan_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatches,
  output int          results_owed
);

  logic [23:0] mod_bytes_cfg;
  logic [31:0] model_cfg;

  logic [POS_W-1:0] word_pos;
  logic [POS_W-1:0] instr_start;
  logic [15:0]      instr_len;
  logic             is_match;
  logic             name_done;
  logic             stopped;
  logic [1:0]       status_code;

  result_t expected_results[$];
  int      err_cnt;

  function void clear_scan();
    word_pos    = '0;
    instr_start = HDR_WORDS;
    instr_len   = '0;
    is_match    = 1'b0;
    name_done   = 1'b0;
    stopped     = 1'b0;
    status_code = ST_OK;
  endfunction

  // One accepted word: advance the scan and queue whatever it yields.
  function void scan_word(input logic [31:0] w, input logic fin);
    logic [POS_W-1:0] wc;
    logic             len_ok;
    int unsigned      p, len, rel, cnt;
    logic [15:0]      op;
    logic [31:0]      chars;
    logic             is_last;
    result_t          r;
    wc     = mod_bytes_cfg[23:2];
    len_ok = (wc > HDR_WORDS) && (mod_bytes_cfg[1:0] == 2'b00);
    p      = word_pos;
    if (len_ok && !stopped && p < wc) begin
      if (p == 0) begin
        if (w != SPV_MAGIC) begin
          stopped     = 1'b1;
          status_code = ST_BAD_MAGIC;
        end
      end else if (p >= HDR_WORDS) begin
        if (p == instr_start + instr_len) begin
          len = w[31:LEN_SHIFT];
          op  = w[15:0];
          if (len == 0 || p + len > wc) begin
            stopped     = 1'b1;
            status_code = ST_BAD_INSTR;
          end else begin
            instr_start = POS_W'(p);
            instr_len   = 16'(len);
            is_match    = (op == OP_ENTRY) && (len > NAME_WORD);
            name_done   = 1'b0;
          end
        end else if (p > instr_start) begin
          rel = p - instr_start;
          if (rel == 1) begin
            if (w != model_cfg) is_match = 1'b0;
          end else if (rel >= NAME_WORD && is_match && !name_done) begin
            chars = '0;
            cnt   = 0;
            while (cnt < 4 && w[8*cnt +: 8] != 8'h00) begin
              chars[8*cnt +: 8] = w[8*cnt +: 8];
              cnt++;
            end
            is_last = (cnt < 4) || (rel + 1 == instr_len);
            if (is_last) name_done = 1'b1;
            r.kind     = KIND_CHUNK;
            r.chars    = chars;
            r.count    = 3'(cnt);
            r.name_end = is_last;
            r.status   = ST_OK;
            expected_results.push_back(r);
          end
        end
      end
    end
    if (word_pos < POS_MAX) word_pos++;
    if (fin) begin
      r.kind     = KIND_REPORT;
      r.chars    = '0;
      r.count    = '0;
      r.name_end = 1'b0;
      r.status   = len_ok ? status_code : ST_BAD_LEN;
      expected_results.push_back(r);
      clear_scan();
    end
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      mod_bytes_cfg = '0;
      model_cfg     = '0;
      clear_scan();
      expected_results.delete();
      err_cnt = 0;
    end else begin
      if (in_valid && !in_stall) scan_word(module_word, final_word);
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_MODULE_BYTES: mod_bytes_cfg = pwdata[23:0];
          REG_WANTED_MODEL: model_cfg = pwdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got.kind     = result_kind;
        got.chars    = name_chars;
        got.count    = char_count;
        got.name_end = name_end;
        got.status   = scan_status;
        if (expected_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result: kind %0d chars %h count %0d end %0d status %0d",
                     got.kind, got.chars, got.count, got.name_end, got.status);
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.chars !== want.chars ||
              got.count !== want.count || got.name_end !== want.name_end ||
              got.status !== want.status) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display({"mismatch (exp/got): kind %0d/%0d chars %h/%h count %0d/%0d ",
                        "end %0d/%0d status %0d/%0d"},
                       want.kind, got.kind, want.chars, got.chars, want.count, got.count,
                       want.name_end, got.name_end, want.status, got.status);
          end
        end
      end
    end
    mismatches   <= err_cnt;
    results_owed <= expected_results.size();
  end

endmodule

[sim/spirv_entry_point_scanner_tb.sv]
// Testbench top for the entry point scanner: stimulus, back pressure and verdict.
module spirv_entry_point_scanner_tb import spe_pkg::*; ();

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int WORD_TARGET = 1925;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] module_word;
  logic        final_word;
  logic        out_valid;
  logic        out_stall;
  logic        result_kind;
  logic [31:0] name_chars;
  logic [2:0]  char_count;
  logic        name_end;
  logic [1:0]  scan_status;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int results_owed;
  int cycles = 0;
  int words_sent = 0;

  logic        tx_busy = 1'b1;
  logic        rx_busy = 1'b1;
  logic        hold_req = 1'b0;
  logic [31:0] cur_model;
  logic [31:0] mod_words[$];

  spirv_entry_point_scanner dut (.*);

  spe_scan_checker checker_i (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stall before each result, plus a long hold-off on request.
  initial begin
    int stall_len;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        stall_len = 300;
      end else begin
        stall_len = rx_busy ? $urandom_range(0, 18) : 0;
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid && !hold_req);
    end
  end

  task automatic reg_write(input logic idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_word(input logic [31:0] w, input logic fin);
    int gap;
    gap = tx_busy ? $urandom_range(0, 18) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    module_word <= w;
    final_word  <= fin;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic send_module();
    foreach (mod_words[i]) send_word(mod_words[i], i == mod_words.size() - 1);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Quiet point: every expected result back, then a short wait for word-only steps.
  task automatic wait_idle();
    do @(posedge clk); while (results_owed != 0);
    repeat (6) @(posedge clk);
  endtask

  // Header plus a random mix of entry points, other instructions and bad counts.
  function automatic void make_module();
    int       n_instr, len, nlen, nw, n_if;
    logic     nul_term, garbage;
    logic [7:0]  ch;
    logic [31:0] nm;
    mod_words.delete();
    mod_words.push_back(($urandom_range(0, 15) == 0) ? $urandom : SPV_MAGIC);
    repeat (4) mod_words.push_back($urandom);
    n_instr = $urandom_range(1, 6);
    repeat (n_instr) begin
      case ($urandom_range(0, 9))
        0: begin
          // zero or overrunning word count
          if ($urandom_range(0, 1))
            mod_words.push_back({16'd0, 16'($urandom)});
          else
            mod_words.push_back({16'($urandom_range(200, 65535)), 16'($urandom)});
        end
        1, 2, 3: begin
          len = $urandom_range(1, 5);
          mod_words.push_back({16'(len), 16'($urandom)});
          repeat (len - 1) mod_words.push_back($urandom);
        end
        default: begin
          nlen     = $urandom_range(0, 15);
          nul_term = $urandom_range(0, 4) != 0;
          garbage  = $urandom_range(0, 3) == 0;
          nw       = nul_term ? nlen / 4 + 1 : (nlen + 3) / 4;
          n_if     = $urandom_range(0, 3);
          len      = 3 + nw + n_if;
          mod_words.push_back({16'(len), OP_ENTRY});
          mod_words.push_back(($urandom_range(0, 3) != 0) ? cur_model : $urandom);
          mod_words.push_back($urandom);
          for (int k = 0; k < nw; k++) begin
            nm = '0;
            for (int b = 0; b < 4; b++) begin
              if (4*k + b < nlen)
                ch = 8'($urandom_range(1, 255));
              else if (nul_term && 4*k + b == nlen)
                ch = 8'h00;
              else if (nul_term)
                ch = garbage ? 8'($urandom) : 8'h00;
              else
                ch = 8'($urandom_range(1, 255));
              nm[8*b +: 8] = ch;
            end
            mod_words.push_back(nm);
          end
          repeat (n_if) mod_words.push_back($urandom);
        end
      endcase
    end
  endfunction

  initial begin
    int          mods_done;
    int          copies;
    int          sz;
    logic [23:0] nbytes;
    in_valid    = 1'b0;
    module_word = '0;
    final_word  = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    cur_model   = '0;
    mods_done   = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // zero length with all-ones word and model
    reg_write(REG_MODULE_BYTES, 32'd0);
    reg_write(REG_WANTED_MODEL, 32'hFFFF_FFFF);
    mod_words = '{32'hFFFF_FFFF};
    send_module();
    wait_idle();

    // bad magic
    reg_write(REG_MODULE_BYTES, 32'd24);
    mod_words = '{32'h0000_0000};
    send_module();
    wait_idle();

    // empty name, name without NUL, then a zero word count
    reg_write(REG_MODULE_BYTES, 32'd60);
    mod_words = '{SPV_MAGIC, 32'h0001_0000, 32'h0, 32'h10, 32'h0,
                  {16'd4, OP_ENTRY}, 32'hFFFF_FFFF, 32'd1, 32'h0000_0000,
                  {16'd5, OP_ENTRY}, 32'hFFFF_FFFF, 32'd2, 32'h6463_6261, 32'h6867_6665,
                  32'h0000_0000};
    send_module();
    wait_idle();

    // largest aligned length, final word early
    reg_write(REG_MODULE_BYTES, 32'h00FF_FFFC);
    mod_words = '{SPV_MAGIC, 32'hFFFF_FFFF};
    send_module();
    wait_idle();

    // words past the module length are ignored
    reg_write(REG_MODULE_BYTES, 32'd24);
    mod_words = '{SPV_MAGIC, 32'h0, 32'h0, 32'h0, 32'h0, {16'd1, 16'd0},
                  32'h0000_1234, 32'hFFFF_FFFF};
    send_module();
    wait_idle();

    while (words_sent < WORD_TARGET) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: cur_model = 32'h0;
          1: cur_model = 32'hFFFF_FFFF;
          2: cur_model = $urandom_range(0, 6);
          default: cur_model = $urandom;
        endcase
        reg_write(REG_WANTED_MODEL, cur_model);
      end
      if ($urandom_range(0, 9) == 0) begin
        mod_words.delete();
        if ($urandom_range(0, 1)) mod_words.push_back(SPV_MAGIC);
        repeat ($urandom_range(1, 8)) mod_words.push_back($urandom);
      end else begin
        make_module();
      end
      sz = mod_words.size();
      case ($urandom_range(0, 15))
        0: nbytes = '0;
        1: nbytes = 24'($urandom_range(1, 20));
        2: nbytes = 24'hFF_FFFF;
        3: nbytes = 24'hFF_FFFC;
        4: nbytes = 24'(4*sz + $urandom_range(1, 3));
        5: nbytes = 24'(4*(sz + $urandom_range(1, 40)));
        6: nbytes = (sz > 7) ? 24'(4*(sz - $urandom_range(1, 2))) : 24'(4*sz);
        default: nbytes = 24'(4*sz);
      endcase
      reg_write(REG_MODULE_BYTES, {8'h00, nbytes});
      tx_busy = $urandom_range(0, 3) != 0;
      rx_busy = $urandom_range(0, 3) != 0;
      copies  = 1;
      // long receiver hold-off while words keep coming, so the input stalls
      if (mods_done == 4 || mods_done == 30) begin
        tx_busy  = 1'b0;
        copies   = 4;
        hold_req = 1'b1;
      end
      repeat (copies) send_module();
      mods_done++;
      wait_idle();
    end

    wait_idle();
    if (mismatches == 0 && results_owed == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
